[rtl/core/bcf_pkg.sv]
// ----------------------------------------------------------------------------
// Bayesian class fusion package
// Shared constants, sequencer states and inter-module structures for the
// recursive label fusion block.
// ----------------------------------------------------------------------------
package bcf_pkg;

    localparam int MAX_ELEMENTS = 4096;
    localparam int MAX_CLASSES  = 16;

    localparam int ID_W       = 12;
    localparam int PROB_W     = 16;
    localparam int SUM_W      = 20;
    localparam int LABEL_W    = 5;
    localparam int CCOUNT_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int ELEM_W  = $clog2(MAX_ELEMENTS);
    localparam int CLASS_W = $clog2(MAX_CLASSES);
    localparam int CNT_W   = $clog2(MAX_CLASSES + 1);
    localparam int ADDR_W  = ELEM_W + CLASS_W;
    localparam int STEP_W  = $clog2(PROB_W);

    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 1'd1;

    localparam logic [CCOUNT_W-1:0] CLASS_COUNT_RESET = CCOUNT_W'(MAX_CLASSES);
    localparam logic [LABEL_W-1:0]  LABEL_NONE        = '1;
    localparam logic [PROB_W-1:0]   PROB_ONE          = '1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_ACC,
        ST_NORM_READ,
        ST_NORM_LOAD,
        ST_NORM_DIV,
        ST_NORM_WRITE
    } t_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PROB_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic              start;
        logic [PROB_W-1:0] dividend;
        logic [SUM_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROB_W-1:0] quotient;
    } t_div_rsp;

endpackage

[rtl/core/bcf_row_store.sv]
// ----------------------------------------------------------------------------
// Probability table store
// Single-port-write, single-port-read memory holding one Q0.16 probability
// per element and class, with registered read data.
// ----------------------------------------------------------------------------
module bcf_row_store (
    input  logic                          i_clk,
    input  bcf_pkg::t_mem_wr              i_wr,
    input  logic [bcf_pkg::ADDR_W-1:0]    i_rd_addr,
    output logic [bcf_pkg::PROB_W-1:0]    o_rd_data
);
    import bcf_pkg::*;

    localparam int DEPTH = MAX_ELEMENTS * MAX_CLASSES;

    logic [PROB_W-1:0] r_mem [DEPTH];
    logic [PROB_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/bcf_div_unit.sv]
// ----------------------------------------------------------------------------
// Serial normalising divider
// Computes (dividend << 16) / divisor one quotient bit per cycle by restoring
// division, saturating at all ones when the dividend reaches the divisor.
// ----------------------------------------------------------------------------
module bcf_div_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcf_pkg::t_div_req  i_req,
    output bcf_pkg::t_div_rsp  o_rsp
);
    import bcf_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_div;
    logic [PROB_W-1:0] r_quo;
    logic [SUM_W:0]    trial;
    logic [SUM_W:0]    diff;
    logic              fits;

    always_comb begin
        trial = {r_rem, 1'b0};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (SUM_W'(i_req.dividend) >= i_req.divisor) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(PROB_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= SUM_W'(i_req.dividend);
            r_div <= i_req.divisor;
            r_quo <= PROB_ONE;
        end else if (r_busy) begin
            r_rem <= fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            r_quo <= {r_quo[PROB_W-2:0], fits};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

[rtl/core/bayes_class_fusion_unit.sv]
// ----------------------------------------------------------------------------
// Bayesian class fusion unit
// Fuses per-class likelihoods into a per-element probability table and
// reports the winning class once each element row is complete.
// ----------------------------------------------------------------------------
// Usage: an input transaction (element_id, likelihood) is taken on a clock edge
// with start high and busy low. Likelihoods of a row arrive in class order.
// Each one is multiplied into the stored probability by the memory read, the
// multiplier and the write-back in turn. The last class of a row is followed,
// unless the row sum is zero, by a normalisation pass that reads each class
// entry, divides it by the row sum in a shared serial divider and writes it
// back. The row's result, the winning class or -1, is shown on o_class_label
// for one cycle with o_valid; busy falls in the same cycle. Only the last
// item of a row gives a result.
// The receiver cannot stall, so results are never held back.
// Configuration transactions are always accepted (o_cfg_ready is high) and
// must be issued while busy is low. After reset the table is filled with the
// uniform prior by a clearing pass, during which busy is high.
// ----------------------------------------------------------------------------
module bayes_class_fusion_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bcf_pkg::ID_W-1:0]          i_element_id,
    input  logic [bcf_pkg::PROB_W-1:0]        i_likelihood,
    output logic                              o_valid,
    output logic signed [bcf_pkg::LABEL_W-1:0] o_class_label,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bcf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bcf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import bcf_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic [CCOUNT_W-1:0] r_class_count;
    logic [PROB_W-1:0]  r_threshold;
    logic [CNT_W-1:0]   r_class_pos;
    logic [SUM_W-1:0]   r_sum;
    logic [ELEM_W-1:0]  r_elem;
    logic [PROB_W-1:0]  r_lik;
    logic [CNT_W-1:0]   r_pos;
    logic               r_last;
    logic [PROB_W-1:0]  r_prod;
    logic [CNT_W-1:0]   r_cidx;
    logic [PROB_W-1:0]  r_best_prob;
    logic [CLASS_W-1:0] r_best_class;
    logic               r_valid;
    logic [LABEL_W-1:0] r_label;

    logic [CNT_W-1:0]    n_active;
    logic [CNT_W-1:0]    pos_eff;
    logic                accept;
    logic [2*PROB_W-1:0] mult;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_sat;
    logic                cidx_last;
    logic                best_take;
    logic [LABEL_W-1:0]  win_label;
    logic [ADDR_W-1:0]   rd_addr;
    logic [PROB_W-1:0]   rd_data;
    t_mem_wr             mem_wr;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    bcf_row_store u_store (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    bcf_div_unit u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        if (r_class_count == '0) begin
            n_active = CNT_W'(1);
        end else if (r_class_count > CCOUNT_W'(MAX_CLASSES)) begin
            n_active = CNT_W'(MAX_CLASSES);
        end else begin
            n_active = CNT_W'(r_class_count);
        end
        pos_eff   = (r_class_pos >= n_active) ? n_active - 1'b1 : r_class_pos;
        accept    = start && (r_state == ST_IDLE);
        mult      = r_lik * rd_data;
        sum_wide  = {1'b0, r_sum} + (SUM_W + 1)'(r_prod);
        sum_sat   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        cidx_last = ((r_cidx + 1'b1) == n_active);
        best_take = (div_rsp.quotient >= r_best_prob);
        win_label = {{(LABEL_W - CLASS_W){1'b0}}, r_best_class};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:      n_state = ST_MUL;
            ST_MUL:       n_state = ST_ACC;
            ST_ACC: begin
                if (r_last && (sum_sat != '0)) begin
                    n_state = ST_NORM_READ;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_NORM_READ: n_state = ST_NORM_LOAD;
            ST_NORM_LOAD: n_state = ST_NORM_DIV;
            ST_NORM_DIV: begin
                if (div_rsp.done) begin
                    n_state = ST_NORM_WRITE;
                end
            end
            ST_NORM_WRITE: begin
                n_state = cidx_last ? ST_IDLE : ST_NORM_READ;
            end
            default:      n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        mem_wr.en        = 1'b0;
        mem_wr.addr      = {r_elem, r_pos[CLASS_W-1:0]};
        mem_wr.data      = r_prod;
        rd_addr          = {r_elem, r_pos[CLASS_W-1:0]};
        div_req.start    = 1'b0;
        div_req.dividend = rd_data;
        div_req.divisor  = r_sum;
        case (r_state)
            ST_CLEAR: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = r_clr_addr;
                mem_wr.data = PROB_ONE;
            end
            ST_ACC: begin
                mem_wr.en = 1'b1;
            end
            ST_NORM_READ: begin
                rd_addr = {r_elem, r_cidx[CLASS_W-1:0]};
            end
            ST_NORM_LOAD: begin
                div_req.start = 1'b1;
            end
            ST_NORM_WRITE: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = {r_elem, r_cidx[CLASS_W-1:0]};
                mem_wr.data = div_rsp.quotient;
            end
            default: begin
                mem_wr.en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_addr    <= '0;
            r_class_count <= CLASS_COUNT_RESET;
            r_threshold   <= '0;
            r_class_pos   <= '0;
            r_sum         <= '0;
            r_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_CLASS_COUNT: r_class_count <= i_cfg_data[CCOUNT_W-1:0];
                    CFG_THRESHOLD:   r_threshold   <= i_cfg_data[PROB_W-1:0];
                    default:         r_threshold   <= r_threshold;
                endcase
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
                ST_ACC: begin
                    if (!r_last) begin
                        r_sum       <= sum_sat;
                        r_class_pos <= r_pos + 1'b1;
                    end else if (sum_sat == '0) begin
                        r_sum       <= '0;
                        r_class_pos <= '0;
                        r_valid     <= 1'b1;
                    end else begin
                        r_sum <= sum_sat;
                    end
                end
                ST_NORM_WRITE: begin
                    if (cidx_last) begin
                        r_sum       <= '0;
                        r_class_pos <= '0;
                        r_valid     <= 1'b1;
                    end
                end
                default: begin
                    r_sum <= r_sum;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_elem <= i_element_id[ELEM_W-1:0];
            r_lik  <= i_likelihood;
            r_pos  <= pos_eff;
            r_last <= ((pos_eff + 1'b1) == n_active);
        end
        if (r_state == ST_MUL) begin
            r_prod <= mult[2*PROB_W-1:PROB_W];
        end
        if (r_state == ST_ACC) begin
            r_cidx       <= '0;
            r_best_prob  <= '0;
            r_best_class <= '0;
            r_label      <= LABEL_NONE;
        end
        if (r_state == ST_NORM_WRITE) begin
            r_cidx <= r_cidx + 1'b1;
            if (best_take) begin
                r_best_prob  <= div_rsp.quotient;
                r_best_class <= r_cidx[CLASS_W-1:0];
            end
            if (cidx_last) begin
                if (best_take) begin
                    r_label <= (div_rsp.quotient >= r_threshold) ?
                               {{(LABEL_W - CLASS_W){1'b0}}, r_cidx[CLASS_W-1:0]} :
                               LABEL_NONE;
                end else begin
                    r_label <= (r_best_prob >= r_threshold) ? win_label : LABEL_NONE;
                end
            end
        end
    end

    assign busy          = (r_state != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_class_label = r_label;
    assign o_cfg_ready   = 1'b1;

    a_valid_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_state == ST_IDLE))
        else $error("Result strobe raised while the sequencer is not idle.");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_NORM_DIV))
        else $error("Divider finished outside the normalisation wait state.");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mem_wr.en)
        else $error("Table written while the sequencer is idle.");

    a_norm_needs_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> (r_sum != '0))
        else $error("Normalisation started with a zero row sum.");

endmodule

[dv/tb_bayes_class_fusion_unit.sv]
// ----------------------------------------------------------------------------
// Bayesian class fusion unit testbench
// Drives likelihood transactions and register writes into the fusion unit.
// A behavioural copy of the probability table predicts each row's label, and
// every label is checked against it in order. Directed rows come first, then
// phases of random rows over many register settings.
// ----------------------------------------------------------------------------
module tb_bayes_class_fusion_unit;
    import bcf_pkg::*;

    localparam int          ITEM_GOAL   = 1550;
    localparam int          STALL_LIMIT = 300000;
    localparam int unsigned SUM_LIMIT   = (1 << SUM_W) - 1;

    typedef struct packed {
        logic [ID_W-1:0]   elem;
        logic [PROB_W-1:0] lik;
    } t_fusion_item;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [ID_W-1:0]              i_element_id = '0;
    logic [PROB_W-1:0]            i_likelihood = '0;
    logic                         o_valid;
    logic signed [LABEL_W-1:0]    o_class_label;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]        i_cfg_data = '0;

    logic [PROB_W-1:0]   prob_mem [MAX_ELEMENTS*MAX_CLASSES];
    int unsigned         row_pos;
    int unsigned         row_sum;
    logic [CCOUNT_W-1:0] cls_count_reg;
    logic [PROB_W-1:0]   thresh_reg;

    t_fusion_item        item_q[$];
    t_fusion_item        next_item;
    logic [LABEL_W-1:0]  exp_labels[$];
    logic [LABEL_W-1:0]  want;
    logic [ID_W-1:0]     hot_ids [8] = '{12'd0, 12'd4095, 12'd1, 12'd2048,
                                         12'd100, 12'd2730, 12'd1365, 12'd7};

    int burst_left = 0;
    int idle_gap = 0;
    int stall_cycles = 0;
    int queued_total = 0;
    int items_taken = 0;
    int rows_done = 0;
    int results_seen = 0;
    int none_seen = 0;
    int reg_writes = 0;
    int mismatches = 0;

    bayes_class_fusion_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_element_id  (i_element_id),
        .i_likelihood  (i_likelihood),
        .o_valid       (o_valid),
        .o_class_label (o_class_label),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned active_classes();
        if (cls_count_reg == 0) return 1;
        if (cls_count_reg > MAX_CLASSES) return MAX_CLASSES;
        return cls_count_reg;
    endfunction

    function automatic void fuse_item(input logic [ID_W-1:0] elem,
                                      input logic [PROB_W-1:0] lik);
        int unsigned        n, pos, base, c;
        logic [31:0]        prod, quot, best_q;
        logic [LABEL_W-1:0] label, best_c;
        n    = active_classes();
        pos  = (row_pos >= n) ? n - 1 : row_pos;
        base = elem * MAX_CLASSES;
        prod = (32'(prob_mem[base + pos]) * 32'(lik)) >> 16;
        prob_mem[base + pos] = prod[PROB_W-1:0];
        row_sum = (row_sum + prod > SUM_LIMIT) ? SUM_LIMIT : row_sum + prod;
        if (pos + 1 < n) begin
            row_pos = pos + 1;
            return;
        end
        if (row_sum == 0) begin
            label = LABEL_NONE;
        end else begin
            best_q = '0;
            best_c = '0;
            for (c = 0; c < n; c++) begin
                quot = {prob_mem[base + c], 16'h0000} / row_sum;
                if (quot > PROB_ONE) quot = PROB_ONE;
                prob_mem[base + c] = quot[PROB_W-1:0];
                if (quot >= best_q) begin
                    best_q = quot;
                    best_c = LABEL_W'(c);
                end
            end
            label = (best_q >= thresh_reg) ? best_c : LABEL_NONE;
        end
        row_pos = 0;
        row_sum = 0;
        rows_done++;
        exp_labels.insert(exp_labels.size(), label);
    endfunction

    function automatic logic [ID_W-1:0] pick_elem();
        if ($urandom_range(0, 1) == 0) return ID_W'($urandom);
        return hot_ids[$urandom_range(0, 7)];
    endfunction

    function automatic logic [PROB_W-1:0] draw_lik(input int mode, input bit hot);
        case (mode)
            0: return PROB_W'($urandom);
            1: return PROB_W'($urandom_range(0, 255));
            2: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return 16'h8000;
                    default: return 16'h0001;
                endcase
            end
            3: return hot ? PROB_W'($urandom_range(60000, 65535))
                          : PROB_W'($urandom_range(0, 2000));
            default: return '0;
        endcase
    endfunction

    task automatic push_item(input logic [ID_W-1:0] elem, input logic [PROB_W-1:0] lik);
        t_fusion_item it;
        it.elem = elem;
        it.lik  = lik;
        item_q.insert(item_q.size(), it);
        queued_total++;
    endtask

    task automatic queue_row(input logic [ID_W-1:0] elem, input int count,
                             input bit scatter);
        int r, mode, hot, k;
        r    = $urandom_range(0, 9);
        mode = (r < 4) ? 0 : (r < 5) ? 1 : (r < 7) ? 2 : (r < 9) ? 3 : 4;
        hot  = $urandom_range(0, count - 1);
        for (k = 0; k < count; k++) begin
            push_item(scatter ? pick_elem() : elem, draw_lik(mode, k == hot));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        if (idx == CFG_CLASS_COUNT) cls_count_reg = data[CCOUNT_W-1:0];
        else if (idx == CFG_THRESHOLD) thresh_reg = data;
        reg_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    // An item that ends no row gives no label, so the unit is also waited on
    // until it has fallen idle.
    task automatic settle();
        do @(posedge i_clk); while (item_q.size() != 0 || start || exp_labels.size() != 0);
        repeat (10) @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH: %s", what);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start        <= 1'b0;
            i_element_id <= '0;
            i_likelihood <= '0;
        end else begin
            if (start && !busy) begin
                fuse_item(i_element_id, i_likelihood);
                items_taken++;
            end
            if (!start || !busy) begin
                if (idle_gap > 0) begin
                    idle_gap--;
                    start <= 1'b0;
                end else if (item_q.size() != 0) begin
                    next_item = item_q.pop_front();
                    start        <= 1'b1;
                    i_element_id <= next_item.elem;
                    i_likelihood <= next_item.lik;
                    if (burst_left <= 1) begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
                        case ($urandom_range(0, 3))
                            0: idle_gap = 0;
                            1: idle_gap = $urandom_range(1, 3);
                            2: idle_gap = $urandom_range(4, 12);
                            default: idle_gap = $urandom_range(0, 40);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            results_seen++;
            if (exp_labels.size() == 0) begin
                report_mismatch($sformatf("label %0d with no transaction pending",
                                          o_class_label));
            end else begin
                want = exp_labels.pop_front();
                if (want == LABEL_NONE) none_seen++;
                if (o_class_label !== want) begin
                    report_mismatch($sformatf("class_label expected %0d, got %0d",
                                              $signed(want), o_class_label));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid === 1'b1 || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout after %0d idle cycles.", stall_cycles);
                $display("bayes_class_fusion_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned         e, n_eff, rows, k, r;
        logic [CCOUNT_W-1:0] cc;
        logic [PROB_W-1:0]   thr;
        for (e = 0; e < MAX_ELEMENTS * MAX_CLASSES; e++) prob_mem[e] = PROB_ONE;
        cls_count_reg = CLASS_COUNT_RESET;
        thresh_reg    = '0;
        row_pos       = 0;
        row_sum       = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b1);
        while (busy !== 1'b0) @(posedge i_clk);

        write_reg(CFG_CLASS_COUNT, 16'h0001);
        write_reg(CFG_THRESHOLD, 16'h0000);
        push_item(12'd0, 16'hFFFF);
        push_item(12'd4095, 16'h0000);
        push_item(12'd4095, 16'hFFFF);
        push_item(12'd1, 16'h0001);
        settle();

        write_reg(CFG_CLASS_COUNT, 16'hFFE4);
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        push_item(12'd7, 16'hFFFF);
        push_item(12'd7, 16'h0000);
        push_item(12'd7, 16'hFFFF);
        push_item(12'd7, 16'hFFFF);
        settle();

        write_reg(CFG_THRESHOLD, 16'h0000);
        push_item(12'd8, 16'hFFFF);
        push_item(12'd8, 16'hFFFF);
        push_item(12'd8, 16'd40000);
        push_item(12'd8, 16'hFFFF);
        settle();

        write_reg(CFG_CLASS_COUNT, 16'h0020);
        push_item(12'd2048, 16'h8000);
        settle();

        write_reg(CFG_CLASS_COUNT, 16'h0008);
        push_item(12'd9, 16'hAAAA);
        push_item(12'd9, 16'h5555);
        push_item(12'd9, 16'hFFFF);
        settle();
        write_reg(CFG_CLASS_COUNT, 16'h0002);
        push_item(12'd9, 16'h1234);
        settle();

        write_reg(CFG_CLASS_COUNT, 16'h0003);
        push_item(12'd20, 16'hFFFF);
        push_item(12'd21, 16'd30000);
        push_item(12'd22, 16'd50000);
        settle();

        while (queued_total < ITEM_GOAL) begin
            case ($urandom_range(0, 7))
                0: cc = 5'd1;
                1: cc = 5'd2;
                2: cc = 5'd16;
                3: cc = 5'd0;
                4: cc = CCOUNT_W'($urandom_range(17, 31));
                default: cc = CCOUNT_W'($urandom_range(1, 16));
            endcase
            write_reg(CFG_CLASS_COUNT, {11'($urandom), cc});
            n_eff = active_classes();
            case ($urandom_range(0, 4))
                0: thr = '0;
                1: thr = '1;
                2: thr = PROB_W'($urandom);
                default: thr = PROB_W'($urandom_range(0, (65536 / n_eff) * 2 - 1));
            endcase
            write_reg(CFG_THRESHOLD, thr);
            rows = $urandom_range(2, (n_eff > 24) ? 2 : 48 / n_eff);
            for (k = 0; k < rows; k++) begin
                r = $urandom_range(0, 9);
                if (r < 8) queue_row(pick_elem(), n_eff, 1'b0);
                else if (r == 8) queue_row(pick_elem(), $urandom_range(1, n_eff + 2), 1'b0);
                else queue_row(pick_elem(), n_eff, 1'b1);
            end
            settle();
        end

        repeat (40) @(posedge i_clk);
        $display("Fused %0d likelihood transactions into %0d labels (%0d reported as none),",
                 items_taken, results_seen, none_seen);
        $display("with %0d register writes and %0d mismatches.", reg_writes, mismatches);
        if (mismatches == 0 && results_seen == rows_done) begin
            $display("bayes_class_fusion_unit test passed");
        end else begin
            $display("bayes_class_fusion_unit test failed");
        end
        $finish;
    end

endmodule
